>>> hw/rtl/ros_pkg.sv
// ----------------------------------------------------------------------------
// Redirect operator spacer package
// Character codes, state record and expansion record shared by the block.
// ----------------------------------------------------------------------------
package ros_pkg;

	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_MARK   = 8'h02;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Most bytes one input byte can expand into.
	localparam int unsigned MAX_OUT = 3;

	typedef logic [1:0] cnt_t;

	typedef struct packed {
		logic in_single;
		logic in_double;
		logic prev_digit;
		logic emitted;
		logic last_space;
		logic after_op;
		logic op_gt;
		logic op_doubled;
	} ros_state_t;

	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		cnt_t                    cnt;
	} ros_exp_t;

endpackage

>>> hw/rtl/ros_if.sv
// ----------------------------------------------------------------------------
// Redirect operator spacer channels
// Valid/ready channels for command bytes and rewritten bytes.
// ----------------------------------------------------------------------------
interface ros_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       line_end;

	modport source (output valid, output in_byte, output line_end, input ready);
	modport sink   (input valid, input in_byte, input line_end, output ready);
endinterface

interface ros_txt_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> hw/rtl/ros_step.sv
// ----------------------------------------------------------------------------
// Redirect operator spacer step
// Expands one command byte into up to three output bytes and gives the
// tracking state that follows it.
// ----------------------------------------------------------------------------
module ros_step (
	input  ros_pkg::ros_state_t state,
	input  logic [7:0]          in_byte,
	input  logic                line_end,
	output ros_pkg::ros_state_t state_nxt,
	output ros_pkg::ros_exp_t   expo
);
	import ros_pkg::*;

	ros_state_t              st;
	logic [MAX_OUT-1:0][7:0] bytes;
	cnt_t                    n;
	logic                    handled;
	logic [7:0]              op;

	always_comb begin
		st      = state;
		bytes   = {MAX_OUT{CH_SPACE}};
		n       = '0;
		handled = 1'b0;
		op      = state.op_gt ? CH_GT : CH_LT;

		// A pending operator either joins one repeat or gets its trailing space.
		if (st.after_op) begin
			if (!st.op_doubled && in_byte == op) begin
				bytes[n]      = in_byte;
				n             = n + 2'd1;
				st.emitted    = 1'b1;
				st.last_space = 1'b0;
				st.op_doubled = 1'b1;
				st.prev_digit = 1'b0;
				handled       = 1'b1;
			end else begin
				if (in_byte != CH_SPACE) begin
					bytes[n]      = CH_SPACE;
					n             = n + 2'd1;
					st.emitted    = 1'b1;
					st.last_space = 1'b1;
				end
				st.after_op   = 1'b0;
				st.op_doubled = 1'b0;
			end
		end

		if (!handled) begin
			if (!st.in_double && in_byte == CH_SQUOTE) begin
				st.in_single = !st.in_single;
			end else if (!st.in_single && in_byte == CH_DQUOTE) begin
				st.in_double = !st.in_double;
			end

			if (!st.in_single && !st.in_double && (in_byte == CH_LT || in_byte == CH_GT)) begin
				if (st.emitted && !st.last_space) begin
					bytes[n]      = CH_SPACE;
					n             = n + 2'd1;
					st.last_space = 1'b1;
				end
				if (st.prev_digit) begin
					bytes[n] = CH_MARK;
					n        = n + 2'd1;
				end
				bytes[n]      = in_byte;
				n             = n + 2'd1;
				st.after_op   = 1'b1;
				st.op_gt      = (in_byte == CH_GT);
				st.op_doubled = 1'b0;
			end else begin
				bytes[n] = in_byte;
				n        = n + 2'd1;
			end
			st.emitted    = 1'b1;
			st.last_space = (in_byte == CH_SPACE) && !(st.after_op && st.op_doubled == 1'b0 &&
				(in_byte == CH_LT || in_byte == CH_GT));
			st.prev_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		end

		if (line_end) begin
			st = '0;
		end
	end

	assign state_nxt  = st;
	assign expo.bytes = bytes;
	assign expo.cnt   = n;

endmodule

>>> hw/rtl/redirect_operator_spacer.sv
// ----------------------------------------------------------------------------
// Redirect operator spacer
// Rewrites a streamed command line so that redirection operators stand apart.
// ----------------------------------------------------------------------------
// The cmd channel takes one character per transaction, with line_end on the
// final character of a line. The txt channel gives the rewritten bytes, with
// out_last on the final byte of the line. Byte 2 marks an operator attached
// to a file descriptor digit.
// Each command byte expands into one to three output bytes, which are held
// in a three-byte output buffer and drained one per cycle while txt is ready.
// The first byte of an item appears on txt the cycle after its transaction.
// A byte that gives one result is taken every cycle while txt is ready; a
// byte that gives more holds cmd.ready low until only its last byte remains
// and txt takes it, as the buffer drains through the single txt port.
// When txt stalls, the buffer holds and cmd.ready stays low until only the
// last buffered byte remains and txt takes it in the same cycle.
// Reset clears the quote and operator tracking and empties the buffer; the
// last byte of a line returns the tracking to the same state.
// ----------------------------------------------------------------------------
module redirect_operator_spacer (
	input  logic          clk,
	input  logic          arst_n,
	ros_cmd_if.sink       cmd,
	ros_txt_if.source     txt
);
	import ros_pkg::*;

	ros_state_t              state_q;
	ros_state_t              state_nxt;
	ros_exp_t                expo;
	logic [MAX_OUT-1:0][7:0] buf_q;
	cnt_t                    rem_q;
	logic                    last_q;
	logic                    take;
	logic                    pop;

	ros_step u_step (
		.state     (state_q),
		.in_byte   (cmd.in_byte),
		.line_end  (cmd.line_end),
		.state_nxt (state_nxt),
		.expo      (expo)
	);

	// Accept when the buffer is empty or its last byte leaves this cycle.
	assign cmd.ready = (rem_q == 2'd0) || (rem_q == 2'd1 && txt.ready);
	assign take      = cmd.valid && cmd.ready;
	assign pop       = txt.valid && txt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			rem_q   <= '0;
		end else if (take) begin
			state_q <= state_nxt;
			rem_q   <= expo.cnt;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q  <= expo.bytes;
			last_q <= cmd.line_end;
		end else if (pop) begin
			buf_q <= {CH_SPACE, buf_q[MAX_OUT-1:1]};
		end
	end

	assign txt.valid    = (rem_q != 2'd0);
	assign txt.out_byte = buf_q[0];
	assign txt.out_last = last_q && (rem_q == 2'd1);

endmodule

>>> hw/rtl/ros_checker.sv
// ----------------------------------------------------------------------------
// Redirect operator spacer checker
// Port-level assertions on the spacer's channels, bound to the top level.
// ----------------------------------------------------------------------------
module ros_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       txt_valid,
	input logic       txt_ready,
	input logic [7:0] txt_out_byte,
	input logic       txt_out_last
);

	// Every accepted transaction yields at least one output byte next cycle.
	a_take_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> txt_valid)
		else $error("no output after accepted command byte");

	// With nothing to send the block must take input.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!txt_valid |-> cmd_ready)
		else $error("idle block refuses input");

	// A stalled receiver must hold input off.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && !txt_ready |-> !cmd_ready)
		else $error("input accepted while output stalled");

	a_txt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && !txt_ready |=> txt_valid && $stable(txt_out_byte) && $stable(txt_out_last))
		else $error("stalled output changed");

endmodule

bind redirect_operator_spacer ros_checker u_ros_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.txt_valid    (txt.valid),
	.txt_ready    (txt.ready),
	.txt_out_byte (txt.out_byte),
	.txt_out_last (txt.out_last)
);
